/* rtl/core/lda_collapsed_gibbs_sampler_top_assert.svh */
// Assertion macros for the topic sampler.
`ifndef LDA_COLLAPSED_GIBBS_SAMPLER_TOP_ASSERT_SVH
`define LDA_COLLAPSED_GIBBS_SAMPLER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LCGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcgs assertion failed");
`define LCGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcgs assertion failed");
`else
`define LCGS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LCGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/lcgs_pkg.sv */
// Shared constants of the topic sampler.
package lcgs_pkg;

  localparam int DOCS_DEF   = 1024;
  localparam int VOCAB_DEF  = 8192;
  localparam int TOPICS_DEF = 128;

  localparam int WT_W  = 20;
  localparam int DT_W  = 16;
  localparam int TT_W  = 24;
  localparam int DS_W  = 16;
  localparam int RW_W  = 48;
  localparam int QB    = 24;

  localparam int NUM_W = WT_W + 9;
  localparam int DEN_W = TT_W + 9;
  localparam int DQ_W  = DT_W + 9;
  localparam int WGT_W = QB + 1 + DQ_W - 8;

  localparam logic [1:0] CFG_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_BETA   = 2'd1;
  localparam logic [1:0] CFG_TOPICS = 2'd2;
  localparam logic [1:0] CFG_VOCAB  = 2'd3;

  localparam logic [15:0] ALPHA_RST  = 16'd128;
  localparam logic [15:0] BETA_RST   = 16'd26;
  localparam logic [7:0]  TOPICS_RST = 8'd100;
  localparam logic [13:0] VOCAB_RST  = 14'd8192;

endpackage

/* rtl/core/lcgs_div.sv */
// Pipelined restoring divider giving a saturated fraction num/den with QB fraction bits.
module lcgs_div #(
  parameter int NUM_W = lcgs_pkg::NUM_W,
  parameter int DEN_W = lcgs_pkg::DEN_W,
  parameter int TAG_W = lcgs_pkg::DQ_W,
  parameter int QB    = lcgs_pkg::QB
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [QB:0]      out_q,
  output logic [TAG_W-1:0] out_tag
);

  localparam logic [1:0] MD_NORM = 2'd0;
  localparam logic [1:0] MD_ZERO = 2'd1;
  localparam logic [1:0] MD_ONE  = 2'd2;

  logic             vld_r [0:QB];
  logic [DEN_W-1:0] rem_r [0:QB];
  logic [DEN_W-1:0] den_r [0:QB];
  logic [QB-1:0]    q_r   [0:QB];
  logic [1:0]       md_r  [0:QB];
  logic [TAG_W-1:0] tag_r [0:QB];

  logic [DEN_W:0]   sh_w    [0:QB-1];
  logic             ge_w    [0:QB-1];
  logic [DEN_W-1:0] rem_nxt [0:QB-1];
  logic [QB-1:0]    q_nxt   [0:QB-1];
  logic [1:0]       md_in;

  always_comb begin
    if (in_den == '0) begin
      md_in = MD_ZERO;
    end else if (DEN_W'(in_num) >= in_den) begin
      md_in = MD_ONE;
    end else begin
      md_in = MD_NORM;
    end
  end

  always_comb begin
    for (int i = 0; i < QB; i++) begin
      sh_w[i]    = {rem_r[i], 1'b0};
      ge_w[i]    = (sh_w[i] >= {1'b0, den_r[i]});
      rem_nxt[i] = ge_w[i] ? DEN_W'(sh_w[i] - {1'b0, den_r[i]}) : DEN_W'(sh_w[i]);
      q_nxt[i]   = {q_r[i][QB-2:0], ge_w[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int i = 0; i < QB; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= DEN_W'(in_num);
    den_r[0] <= in_den;
    q_r[0]   <= '0;
    md_r[0]  <= md_in;
    tag_r[0] <= in_tag;
    for (int i = 0; i < QB; i++) begin
      rem_r[i+1] <= rem_nxt[i];
      den_r[i+1] <= den_r[i];
      q_r[i+1]   <= q_nxt[i];
      md_r[i+1]  <= md_r[i];
      tag_r[i+1] <= tag_r[i];
    end
  end

  always_comb begin
    case (md_r[QB])
      MD_ONE:  out_q = {1'b1, {QB{1'b0}}};
      MD_ZERO: out_q = '0;
      default: out_q = {1'b0, q_r[QB]};
    endcase
  end

  assign out_vld = vld_r[QB];
  assign out_tag = tag_r[QB];

endmodule

/* rtl/core/lda_collapsed_gibbs_sampler_top.sv */
// Collapsed Gibbs topic sampler: count tables in memories, pipelined weight sweep and draw.
// A new item is taken only from idle, once the last one is through; a resample sweeps K,
// the topics in use, with one weight per cycle through the 25-stage divider and one
// running-sum read per cycle.
// After reset a clearing pass over max(VOCAB, DOCS)*TOPICS addresses zeroes the count
// memories, during which no item is taken; configuration writes are taken throughout.
`include "lda_collapsed_gibbs_sampler_top_assert.svh"
module lda_collapsed_gibbs_sampler_top #(
  parameter int DOCS   = lcgs_pkg::DOCS_DEF,
  parameter int VOCAB  = lcgs_pkg::VOCAB_DEF,
  parameter int TOPICS = lcgs_pkg::TOPICS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [9:0]  in_doc_index,
  input  logic [12:0] in_word_id,
  input  logic [6:0]  in_topic,
  input  logic [31:0] in_random_fraction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_new_topic
);

  localparam int WT_DEPTH  = VOCAB * TOPICS;
  localparam int DT_DEPTH  = DOCS * TOPICS;
  localparam int CLR_DEPTH = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
  localparam int WA = $clog2(WT_DEPTH);
  localparam int DA = $clog2(DT_DEPTH);
  localparam int CA = $clog2(CLR_DEPTH);
  localparam int TW = $clog2(TOPICS);
  localparam int KW = TW + 1;
  localparam int DW = (DOCS > 1) ? $clog2(DOCS) : 1;
  localparam int VW = $clog2(VOCAB);

  localparam int WT_W  = lcgs_pkg::WT_W;
  localparam int DT_W  = lcgs_pkg::DT_W;
  localparam int TT_W  = lcgs_pkg::TT_W;
  localparam int DS_W  = lcgs_pkg::DS_W;
  localparam int RW_W  = lcgs_pkg::RW_W;
  localparam int QB    = lcgs_pkg::QB;
  localparam int NUM_W = lcgs_pkg::NUM_W;
  localparam int DEN_W = lcgs_pkg::DEN_W;
  localparam int DQ_W  = lcgs_pkg::DQ_W;
  localparam int WGT_W = lcgs_pkg::WGT_W;

  localparam logic [3:0] ST_CLR     = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DEC_RD  = 4'd2;
  localparam logic [3:0] ST_DEC_WB  = 4'd3;
  localparam logic [3:0] ST_SWEEP   = 4'd4;
  localparam logic [3:0] ST_DRAIN   = 4'd5;
  localparam logic [3:0] ST_THR_LO  = 4'd6;
  localparam logic [3:0] ST_THR_HI  = 4'd7;
  localparam logic [3:0] ST_THR_SUM = 4'd8;
  localparam logic [3:0] ST_SCAN    = 4'd9;
  localparam logic [3:0] ST_INC_RD  = 4'd10;
  localparam logic [3:0] ST_INC_WB  = 4'd11;
  localparam logic [3:0] ST_DONE    = 4'd12;

  logic [15:0] alpha_r;
  logic [15:0] beta_r;
  logic [7:0]  tiu_r;
  logic [13:0] vocab_r;

  logic [3:0]  state_r, state_nxt;
  logic [CA-1:0] clr_r;

  logic          op_r;
  logic [DW-1:0] d_r;
  logic [TW-1:0] t_r;
  logic [TW-1:0] tn_r;
  logic [31:0]   r_r;
  logic [KW-1:0] kn_r;
  logic [29:0]   vb_r;
  logic [WA-1:0] wt_base_r;
  logic [DA-1:0] dt_base_r;

  logic [DW-1:0] d_c;
  logic [VW-1:0] w_c;
  logic [TW-1:0] t_c;
  logic [KW-1:0] kn_c;
  logic [TW-1:0] klast;

  logic [WT_W-1:0] wt_mem_r [WT_DEPTH];
  logic [DT_W-1:0] dt_mem_r [DT_DEPTH];
  logic [TT_W-1:0] tt_mem_r [TOPICS];
  logic [DS_W-1:0] ds_mem_r [DOCS];
  logic [RW_W-1:0] rw_mem_r [TOPICS];

  logic [WT_W-1:0] wt_rd_r;
  logic [DT_W-1:0] dt_rd_r;
  logic [TT_W-1:0] tt_rd_r;
  logic [DS_W-1:0] ds_rd_r;
  logic [RW_W-1:0] rw_rd_r;

  logic [TW-1:0] sel;
  logic [WA-1:0] wt_ra;
  logic [DA-1:0] dt_ra;
  logic          cnt_we, clr_go, up;
  logic [WA-1:0] wt_wa;
  logic [DA-1:0] dt_wa;
  logic [TW-1:0] tt_wa;
  logic [DW-1:0] ds_wa;
  logic          wt_we, dt_we, tt_we, ds_we;
  logic [WT_W-1:0] wt_wd;
  logic [DT_W-1:0] dt_wd;
  logic [TT_W-1:0] tt_wd;
  logic [DS_W-1:0] ds_wd;

  logic [TW-1:0] k_r;
  logic          sw_vld_r;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [DQ_W-1:0]  div_tag;
  logic             div_vld;
  logic [QB:0]      div_q;
  logic [DQ_W-1:0]  div_dq;

  logic             mvld_r;
  logic [WGT_W-1:0] wgt_r;
  logic [TW-1:0]    acc_k_r;
  logic [RW_W-1:0]  sum_r;
  logic [RW_W:0]    sum_add;
  logic [RW_W-1:0]  sum_nxt;

  logic [63:0]     plo_r;
  logic [47:0]     phi_r;
  logic [RW_W-1:0] u_r;

  logic [TW-1:0] sk_r;
  logic          sc_more_r;
  logic          scan_vld_r;
  logic [TW-1:0] scan_k_r;
  logic          scan_hit, scan_end;

  logic       out_valid_r;
  logic [6:0] out_topic_r;
  logic       out_load;

  assign d_c = (32'(in_doc_index) >= DOCS) ? DW'(DOCS - 1) : DW'(in_doc_index);
  assign w_c = (32'(in_word_id) >= VOCAB) ? VW'(VOCAB - 1) : VW'(in_word_id);
  assign t_c = (32'(in_topic) >= TOPICS) ? TW'(TOPICS - 1) : TW'(in_topic);

  always_comb begin
    if (tiu_r == 8'd0) begin
      kn_c = KW'(1);
    end else if (32'(tiu_r) > TOPICS) begin
      kn_c = KW'(TOPICS);
    end else begin
      kn_c = KW'(tiu_r);
    end
  end

  assign klast    = TW'(kn_r - KW'(1));
  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= lcgs_pkg::ALPHA_RST;
      beta_r  <= lcgs_pkg::BETA_RST;
      tiu_r   <= lcgs_pkg::TOPICS_RST;
      vocab_r <= lcgs_pkg::VOCAB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lcgs_pkg::CFG_ALPHA:  alpha_r <= cfg_wdata;
        lcgs_pkg::CFG_BETA:   beta_r  <= cfg_wdata;
        lcgs_pkg::CFG_TOPICS: tiu_r   <= cfg_wdata[7:0];
        lcgs_pkg::CFG_VOCAB:  vocab_r <= cfg_wdata[13:0];
        default: ;
      endcase
    end
  end

  assign scan_hit = scan_vld_r && (rw_rd_r > u_r);
  assign scan_end = scan_vld_r && (scan_k_r == klast);
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:     if (clr_r == CA'(CLR_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:    if (in_valid) state_nxt = in_opcode ? ST_DEC_RD : ST_INC_RD;
      ST_DEC_RD:  state_nxt = ST_DEC_WB;
      ST_DEC_WB:  state_nxt = ST_SWEEP;
      ST_SWEEP:   if (k_r == klast) state_nxt = ST_DRAIN;
      ST_DRAIN:   if (mvld_r && acc_k_r == klast) state_nxt = ST_THR_LO;
      ST_THR_LO:  state_nxt = ST_THR_HI;
      ST_THR_HI:  state_nxt = ST_THR_SUM;
      ST_THR_SUM: state_nxt = ST_SCAN;
      ST_SCAN:    if (scan_hit || scan_end) state_nxt = ST_INC_RD;
      ST_INC_RD:  state_nxt = ST_INC_WB;
      ST_INC_WB:  state_nxt = ST_DONE;
      ST_DONE:    if (out_load) state_nxt = ST_IDLE;
      default:    state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      sw_vld_r    <= 1'b0;
      mvld_r      <= 1'b0;
      scan_vld_r  <= 1'b0;
      sc_more_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sw_vld_r <= (state_r == ST_SWEEP);
      mvld_r   <= div_vld;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + CA'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_THR_SUM) begin
        sc_more_r <= 1'b1;
      end else if (state_r == ST_SCAN && sc_more_r && sk_r == klast) begin
        sc_more_r <= 1'b0;
      end
      scan_vld_r <= (state_r == ST_SCAN) && sc_more_r && !scan_hit && !scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r      <= in_opcode;
      d_r       <= d_c;
      t_r       <= t_c;
      tn_r      <= t_c;
      r_r       <= in_random_fraction;
      kn_r      <= kn_c;
      vb_r      <= 30'(vocab_r) * 30'(beta_r);
      wt_base_r <= WA'(w_c * TOPICS);
      dt_base_r <= DA'(d_c * TOPICS);
      k_r       <= '0;
      acc_k_r   <= '0;
      sum_r     <= '0;
    end
    if (state_r == ST_SWEEP) begin
      k_r <= k_r + TW'(1);
    end
    if (mvld_r) begin
      sum_r   <= sum_nxt;
      acc_k_r <= acc_k_r + TW'(1);
    end
    if (state_r == ST_THR_LO) begin
      plo_r <= 64'(r_r) * 64'(sum_r[31:0]);
    end
    if (state_r == ST_THR_HI) begin
      phi_r <= 48'(r_r) * 48'(sum_r[47:32]);
    end
    if (state_r == ST_THR_SUM) begin
      u_r  <= phi_r + 48'(plo_r[63:32]);
      sk_r <= '0;
    end
    if (state_r == ST_SCAN && sc_more_r) begin
      sk_r     <= sk_r + TW'(1);
      scan_k_r <= sk_r;
    end
    if (state_r == ST_SCAN) begin
      if (scan_hit) begin
        tn_r <= scan_k_r;
      end else if (scan_end) begin
        tn_r <= klast;
      end
    end
    if (out_load) begin
      out_topic_r <= 7'(tn_r);
    end
  end

  always_comb begin
    case (state_r)
      ST_SWEEP:                sel = k_r;
      ST_INC_RD, ST_INC_WB:    sel = tn_r;
      default:                 sel = t_r;
    endcase
  end

  assign wt_ra  = wt_base_r + WA'(sel);
  assign dt_ra  = dt_base_r + DA'(sel);
  assign clr_go = (state_r == ST_CLR);
  assign cnt_we = (state_r == ST_DEC_WB) || (state_r == ST_INC_WB);
  assign up     = (state_r == ST_INC_WB);

  always_comb begin
    wt_we = cnt_we || (clr_go && 32'(clr_r) < WT_DEPTH);
    dt_we = cnt_we || (clr_go && 32'(clr_r) < DT_DEPTH);
    tt_we = cnt_we || (clr_go && 32'(clr_r) < TOPICS);
    ds_we = cnt_we || (clr_go && 32'(clr_r) < DOCS);
    if (clr_go) begin
      wt_wa = WA'(clr_r);
      dt_wa = DA'(clr_r);
      tt_wa = TW'(clr_r);
      ds_wa = DW'(clr_r);
      wt_wd = '0;
      dt_wd = '0;
      tt_wd = '0;
      ds_wd = '0;
    end else begin
      wt_wa = wt_ra;
      dt_wa = dt_ra;
      tt_wa = sel;
      ds_wa = d_r;
      if (up) begin
        wt_wd = (wt_rd_r == '1) ? wt_rd_r : wt_rd_r + WT_W'(1);
        dt_wd = (dt_rd_r == '1) ? dt_rd_r : dt_rd_r + DT_W'(1);
        tt_wd = (tt_rd_r == '1) ? tt_rd_r : tt_rd_r + TT_W'(1);
        ds_wd = (ds_rd_r == '1) ? ds_rd_r : ds_rd_r + DS_W'(1);
      end else begin
        wt_wd = (wt_rd_r == '0) ? wt_rd_r : wt_rd_r - WT_W'(1);
        dt_wd = (dt_rd_r == '0) ? dt_rd_r : dt_rd_r - DT_W'(1);
        tt_wd = (tt_rd_r == '0) ? tt_rd_r : tt_rd_r - TT_W'(1);
        ds_wd = (ds_rd_r == '0) ? ds_rd_r : ds_rd_r - DS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem_r[wt_wa] <= wt_wd;
    end
    wt_rd_r <= wt_mem_r[wt_ra];
  end

  always_ff @(posedge clk) begin
    if (dt_we) begin
      dt_mem_r[dt_wa] <= dt_wd;
    end
    dt_rd_r <= dt_mem_r[dt_ra];
  end

  always_ff @(posedge clk) begin
    if (tt_we) begin
      tt_mem_r[tt_wa] <= tt_wd;
    end
    tt_rd_r <= tt_mem_r[sel];
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      ds_mem_r[ds_wa] <= ds_wd;
    end
    ds_rd_r <= ds_mem_r[d_r];
  end

  always_ff @(posedge clk) begin
    if (mvld_r) begin
      rw_mem_r[acc_k_r] <= sum_nxt;
    end
    rw_rd_r <= rw_mem_r[sk_r];
  end

  assign div_num = NUM_W'({wt_rd_r, 8'b0}) + NUM_W'(beta_r);
  assign div_den = DEN_W'({tt_rd_r, 8'b0}) + DEN_W'(vb_r);
  assign div_tag = DQ_W'({dt_rd_r, 8'b0}) + DQ_W'(alpha_r);

  lcgs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .TAG_W (DQ_W),
    .QB    (QB)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sw_vld_r),
    .in_num  (div_num),
    .in_den  (div_den),
    .in_tag  (div_tag),
    .out_vld (div_vld),
    .out_q   (div_q),
    .out_tag (div_dq)
  );

  always_ff @(posedge clk) begin
    wgt_r <= WGT_W'((50'(div_q) * 50'(div_dq)) >> 8);
  end

  assign sum_add = {1'b0, sum_r} + (RW_W + 1)'(wgt_r);
  assign sum_nxt = sum_add[RW_W] ? {RW_W{1'b1}} : sum_add[RW_W-1:0];

  assign out_valid     = out_valid_r;
  assign out_new_topic = out_topic_r;

  `LCGS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r != ST_IDLE)
  `LCGS_ASSERT_NOW(a_clear_blocks_input, clk, rst_n, state_r == ST_CLR, !in_ready)
  `LCGS_ASSERT_NOW(a_scan_after_drain, clk, rst_n, state_r == ST_SCAN, !mvld_r && !div_vld)
  `LCGS_ASSERT_NOW(a_draw_in_range, clk, rst_n, state_r == ST_INC_RD && op_r, (KW'(tn_r) < kn_r))

endmodule
